// ===== rtl/core/slid_pkg.sv =====
// Package: shared constants, types and codes of the sorted list core.
package slid_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DISP
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [DataW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] result_value;
    logic                    last;
  } out_item_t;

  // Per-cell control: broadcast op plus position flags relative to the fill count.
  typedef struct packed {
    cell_op_e op;
    logic     found;   // some cell matched on delete
    logic     occ;     // cell holds a stored value
    logic     at_end;  // cell is the first free slot
    logic     tail;    // cell holds the largest stored value
  } cell_ctl_t;

endpackage

// ===== rtl/core/slid_cell.sv =====
// One storage cell of the sorted list chain.
module slid_cell (
  input  logic                            clk_i,
  input  slid_pkg::cell_ctl_t             ctl_i,
  input  logic signed [slid_pkg::DataW-1:0] key_i,
  input  logic signed [slid_pkg::DataW-1:0] left_val_i,
  input  logic                            left_ge_i,
  input  logic signed [slid_pkg::DataW-1:0] right_val_i,
  input  logic signed [slid_pkg::DataW-1:0] head_val_i,
  output logic signed [slid_pkg::DataW-1:0] val_o,
  output logic                            ge_o,
  output logic                            eq_o
);

  logic signed [slid_pkg::DataW-1:0] val_q, val_d;
  logic lt;

  assign lt    = val_q < key_i;
  assign ge_o  = ctl_i.occ && !lt;
  assign eq_o  = ctl_i.occ && (val_q == key_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    unique case (ctl_i.op)
      slid_pkg::CELL_INS: begin
        // shift right from the insert point, drop the key into the gap
        if (left_ge_i) begin
          val_d = left_val_i;
        end else if (ge_o || ctl_i.at_end) begin
          val_d = key_i;
        end
      end
      slid_pkg::CELL_DEL: begin
        // everything at or past the first match closes up to the left
        if (ctl_i.found && ge_o) begin
          val_d = right_val_i;
        end
      end
      slid_pkg::CELL_ROT: begin
        if (ctl_i.tail) begin
          val_d = head_val_i;
        end else if (ctl_i.occ) begin
          val_d = right_val_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== rtl/core/sorted_list_insert_delete_core.sv =====
// Top level: sorted list of signed values kept in a chain of shifting cells.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------
//  in      | in  | in_valid_i / in_ready_o | in_data_i  (cmd, value)
//  out     | out | out_valid_o/out_ready_i | out_data_o (status, value, last)
//
// Insert and delete accept the transfer in ST_IDLE, then in ST_EXEC every cell
// compares against the key and shifts in parallel.
// List accepts the transfer in ST_IDLE and passes ST_EXEC into ST_DISP, where the
// ring rotates by one position per cycle while the output register can take a
// result, cell 0 feeding the output, and is back in place after entry_count steps.
// An item may be accepted while a result still sits in the output register;
// the execute and list steps wait only while that register is full and not being read.
// Reset empties the list (fill count to zero); cell contents are not cleared.
module sorted_list_insert_delete_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slid_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slid_pkg::out_item_t out_data_o
);

  localparam int unsigned Cap  = slid_pkg::Capacity;
  localparam int unsigned CntW = slid_pkg::CntW;
  localparam int unsigned DW   = slid_pkg::DataW;

  slid_pkg::state_e    state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     idx_q, idx_d;    // position of the entry being listed
  logic [1:0]          cmd_q, cmd_d;
  logic signed [DW-1:0] key_q, key_d;
  logic                out_valid_q, out_valid_d;
  slid_pkg::out_item_t out_q, out_d;

  slid_pkg::cell_op_e  cell_op;
  logic                slot_free;
  logic                found;
  logic                full;
  logic                empty;
  logic                list_last;

  // Chain wiring
  logic signed [DW-1:0] cell_val [Cap];
  logic [Cap-1:0]       cell_ge;
  logic [Cap-1:0]       cell_eq;

  assign found     = |cell_eq;
  assign full      = (count_q == CntW'(Cap));
  assign empty     = (count_q == '0);
  assign list_last = (idx_q == count_q - CntW'(1));
  assign slot_free = !out_valid_q || out_ready_i;

  for (genvar i = 0; i < Cap; i++) begin : g_cell
    slid_pkg::cell_ctl_t   ctl;
    logic signed [DW-1:0]  left_val;
    logic                  left_ge;
    logic signed [DW-1:0]  right_val;

    assign ctl.op     = cell_op;
    assign ctl.found  = found;
    assign ctl.occ    = (CntW'(i) < count_q);
    assign ctl.at_end = (CntW'(i) == count_q);
    assign ctl.tail   = (CntW'(i + 1) == count_q);

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_ge  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
      assign left_ge  = cell_ge[i-1];
    end

    if (i == Cap - 1) begin : g_last
      assign right_val = '0;   // beyond the fill count after a delete
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    slid_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .key_i       (key_q),
      .left_val_i  (left_val),
      .left_ge_i   (left_ge),
      .right_val_i (right_val),
      .head_val_i  (cell_val[0]),
      .val_o       (cell_val[i]),
      .ge_o        (cell_ge[i]),
      .eq_o        (cell_eq[i])
    );
  end

  // Control
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cell_op     = slid_pkg::CELL_HOLD;
    in_ready_o  = 1'b0;

    unique case (state_q)
      slid_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = in_data_i.cmd;
          key_d   = in_data_i.value;
          state_d = slid_pkg::ST_EXEC;
        end
      end

      slid_pkg::ST_EXEC: begin
        if (slot_free) begin
          state_d           = slid_pkg::ST_IDLE;
          out_d.result_value = '0;
          out_d.last        = 1'b1;
          case (cmd_q)
            slid_pkg::CMD_INSERT: begin
              out_valid_d = 1'b1;
              if (full) begin
                out_d.status = slid_pkg::STAT_FULL;
              end else begin
                cell_op      = slid_pkg::CELL_INS;
                count_d      = count_q + CntW'(1);
                out_d.status = slid_pkg::STAT_OK;
              end
            end
            slid_pkg::CMD_DELETE: begin
              out_valid_d = 1'b1;
              if (empty) begin
                out_d.status = slid_pkg::STAT_EMPTY;
              end else if (!found) begin
                out_d.status = slid_pkg::STAT_NOT_FOUND;
              end else begin
                // the removed entry equals the key
                cell_op            = slid_pkg::CELL_DEL;
                count_d            = count_q - CntW'(1);
                out_d.status       = slid_pkg::STAT_OK;
                out_d.result_value = key_q;
              end
            end
            slid_pkg::CMD_LIST: begin
              if (empty) begin
                out_valid_d  = 1'b1;
                out_d.status = slid_pkg::STAT_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = slid_pkg::ST_DISP;
              end
            end
            default: begin
              // unused command: no result
            end
          endcase
        end
      end

      slid_pkg::ST_DISP: begin
        if (slot_free) begin
          cell_op            = slid_pkg::CELL_ROT;
          out_valid_d        = 1'b1;
          out_d.status       = slid_pkg::STAT_OK;
          out_d.result_value = cell_val[0];
          out_d.last         = list_last;
          idx_d              = idx_q + CntW'(1);
          if (list_last) begin
            state_d = slid_pkg::ST_IDLE;
          end
        end
      end

      default: state_d = slid_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slid_pkg::ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    key_q <= key_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/slid_checker.sv =====
// Checker: mirrors the sorted list, predicts every result and compares the output channel.
module slid_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  slid_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  slid_pkg::out_item_t out_data_i,
  output int                  err_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [slid_pkg::DataW-1:0] sorted_vals [slid_pkg::Capacity];
  int unsigned                       fill;
  slid_pkg::out_item_t               due_results [$];

  task automatic add_due(slid_pkg::status_e st, logic signed [slid_pkg::DataW-1:0] val,
                         logic lst);
    slid_pkg::out_item_t r;
    r.status       = st;
    r.result_value = val;
    r.last         = lst;
    due_results.push_back(r);
  endtask

  // Apply one command to the mirror list and queue what it should produce.
  task automatic apply_command(slid_pkg::in_item_t it);
    int unsigned pos;
    int unsigned i;
    logic signed [slid_pkg::DataW-1:0] gone;
    case (it.cmd)
      slid_pkg::CMD_INSERT: begin
        if (fill >= slid_pkg::Capacity) begin
          add_due(slid_pkg::STAT_FULL, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < fill && sorted_vals[pos] < it.value) pos++;
          for (i = fill; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
          sorted_vals[pos] = it.value;
          fill++;
          add_due(slid_pkg::STAT_OK, '0, 1'b1);
        end
      end
      slid_pkg::CMD_DELETE: begin
        if (fill == 0) begin
          add_due(slid_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < fill && sorted_vals[pos] != it.value) pos++;
          if (pos >= fill) begin
            add_due(slid_pkg::STAT_NOT_FOUND, '0, 1'b1);
          end else begin
            gone = sorted_vals[pos];
            for (i = pos; i + 1 < fill; i++) sorted_vals[i] = sorted_vals[i+1];
            fill--;
            add_due(slid_pkg::STAT_OK, gone, 1'b1);
          end
        end
      end
      slid_pkg::CMD_LIST: begin
        if (fill == 0) begin
          add_due(slid_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < fill; i++) add_due(slid_pkg::STAT_OK, sorted_vals[i], (i + 1 == fill));
        end
      end
      default: ; // unused code: no transfer out
    endcase
  endtask

  task automatic compare_result(slid_pkg::out_item_t got);
    slid_pkg::out_item_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result: status %0d value %0d last %0d",
             got.status, got.result_value, got.last);
      err_count_o++;
    end else begin
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        err_count_o++;
      end
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %0d, got %0d", want.result_value, got.result_value);
        err_count_o++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        err_count_o++;
      end
    end
  endtask

  // Output side first: a result leaving now never belongs to a command taken now.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill = 0;
      err_count_o = 0;
      due_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) compare_result(out_data_i);
      if (in_valid_i && in_ready_i) apply_command(in_data_i);
    end
    pending_o = due_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, command stimulus, output back-pressure and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Code 3 is not decoded by the block; it must be swallowed without a transfer out.
  localparam logic [1:0]                 CmdUnused     = 2'd3;
  localparam logic [slid_pkg::DataW-1:0] MinVal        = 32'h8000_0000;
  localparam logic [slid_pkg::DataW-1:0] MaxVal        = 32'h7fff_ffff;
  localparam int                         WatchdogLimit = 3000;
  localparam int                         DrainCycles   = 10;

  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  slid_pkg::in_item_t  in_data    = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  slid_pkg::out_item_t out_data;

  int        err_count;
  int        pending;
  int        idle_cycles = 0;
  int        stall_left  = 0;
  bit        no_idle     = 1'b0;   // when set, neither side inserts gaps
  logic [slid_pkg::DataW-1:0] pool [8];   // recycled values so deletes find matches

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  sorted_list_insert_delete_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  slid_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Value mix: pool hits (duplicates, delete matches), extremes, full-range random.
  function automatic logic [slid_pkg::DataW-1:0] pick_value(int pool_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < pool_pct) return pool[3'($urandom_range(0, 7))];
    if (r < pool_pct + 12) begin
      case ($urandom_range(0, 4))
        0:       return MinVal;
        1:       return MaxVal;
        2:       return '0;
        3:       return '1;
        default: return 32'd1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic refill_pool();
    for (int i = 0; i < 8; i++) begin
      pool[3'(i)] = (i < 3) ? $urandom_range(0, 20) - 10 : $urandom();
    end
  endtask

  // One input transfer: optional gap, then hold valid and payload until taken.
  task automatic send_item(logic [1:0] cmd, logic [slid_pkg::DataW-1:0] val);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid      <= 1'b1;
    in_data.cmd   <= cmd;
    in_data.value <= val;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Sender holds off until every predicted result has left the block.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Random commands; only decoded commands count toward n.
  task automatic run_mix(int n, int w_ins, int w_del, int pool_pct);
    int sent;
    int r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) begin
        send_item(slid_pkg::CMD_INSERT, pick_value(pool_pct));
        sent++;
      end else if (r < w_ins + w_del) begin
        send_item(slid_pkg::CMD_DELETE, pick_value(pool_pct));
        sent++;
      end else if (r < 96) begin
        send_item(slid_pkg::CMD_LIST, $urandom());
        sent++;
      end else begin
        send_item(CmdUnused, $urandom());
      end
    end
  endtask

  // Receiver: runs of ready broken by random stalls, none while no_idle is set.
  initial begin
    forever begin
      @(negedge clk_i);
      if (no_idle) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: too long without any transfer on either channel means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    refill_pool();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list cases, unused code, extremes, duplicates, head/tail deletes.
    send_item(slid_pkg::CMD_LIST,   '0);
    send_item(slid_pkg::CMD_DELETE, MaxVal);
    send_item(CmdUnused,            MinVal);
    send_item(slid_pkg::CMD_INSERT, '0);
    send_item(slid_pkg::CMD_INSERT, MinVal);
    send_item(slid_pkg::CMD_INSERT, MaxVal);
    send_item(slid_pkg::CMD_INSERT, '1);
    send_item(slid_pkg::CMD_INSERT, 32'd1);
    send_item(slid_pkg::CMD_INSERT, '0);
    send_item(slid_pkg::CMD_LIST,   MaxVal);
    send_item(slid_pkg::CMD_DELETE, 32'd5);
    send_item(slid_pkg::CMD_DELETE, MinVal);
    send_item(slid_pkg::CMD_DELETE, MaxVal);
    send_item(slid_pkg::CMD_DELETE, '0);
    send_item(slid_pkg::CMD_LIST,   '1);
    send_item(slid_pkg::CMD_DELETE, '0);
    send_item(slid_pkg::CMD_DELETE, '1);
    send_item(slid_pkg::CMD_DELETE, 32'd1);
    send_item(slid_pkg::CMD_LIST,   '0);
    send_item(CmdUnused,            MaxVal);
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    // Mixed traffic on a short list.
    run_mix(20, 50, 30, 40);
    wait_drained();

    // Fill past capacity: guarantees full-list rejects, then a full-length list.
    refill_pool();
    for (int i = 0; i < slid_pkg::Capacity + 4; i++) begin
      send_item(slid_pkg::CMD_INSERT, pick_value(30));
    end
    send_item(slid_pkg::CMD_LIST, $urandom());

    // Drain: delete-heavy with pool values so most deletes hit.
    run_mix(30, 20, 60, 70);
    wait_drained();

    // Back-to-back stretch with no gaps on either side.
    no_idle = 1'b1;
    run_mix(15, 40, 35, 60);
    no_idle = 1'b0;

    // End: nothing outstanding, then let any trailing work settle.
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
